// ----- rtl/icp_pkg.sv -----
// Shared types, codes and decode helpers for the intcode processor.
// Used by the top level and the testbench; no dependencies.
package icp_pkg;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_COPY, S_FETCH, S_FWAIT, S_DEC, S_DEC2, S_PAR, S_PWAIT,
    S_OPR, S_OPA, S_OPB, S_EXEC, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_ADV,
    S_MODW, S_NEXT, S_EMIT
  } state_t;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_PUSH    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_RUN     = 2'd3;

  localparam logic [2:0] ST_OUTPUT   = 3'd0;
  localparam logic [2:0] ST_HALT     = 3'd1;
  localparam logic [2:0] ST_BADMODE  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_UNDERRUN = 3'd4;

  localparam logic [6:0] OP_ADD  = 7'd1;
  localparam logic [6:0] OP_MUL  = 7'd2;
  localparam logic [6:0] OP_IN   = 7'd3;
  localparam logic [6:0] OP_OUT  = 7'd4;
  localparam logic [6:0] OP_JT   = 7'd5;
  localparam logic [6:0] OP_JF   = 7'd6;
  localparam logic [6:0] OP_LT   = 7'd7;
  localparam logic [6:0] OP_EQ   = 7'd8;
  localparam logic [6:0] OP_ARB  = 7'd9;
  localparam logic [6:0] OP_HALT = 7'd99;

  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  // The low five decimal digits hold the opcode and the three mode digits.
  localparam int DEC_BASE = 100000;
  localparam int DEC_W    = 17;

  localparam int RUN_BUDGET = 65536;
  localparam int BW         = $clog2(RUN_BUDGET + 1);

  // Exact floor(r / 100) for r below 100000.
  function automatic logic [9:0] div100(input logic [16:0] r);
    logic [34:0] p;
    p = 35'(r) * 35'd167773;
    return p[33:24];
  endfunction

  // Exact floor(m / 10) for m below 1000.
  function automatic logic [6:0] div10(input logic [9:0] m);
    logic [17:0] p;
    p = 18'(m) * 18'd205;
    return p[17:11];
  endfunction

  // Exact floor(m / 100) for m below 1000.
  function automatic logic [3:0] div100s(input logic [9:0] m);
    logic [15:0] p;
    p = 16'(m) * 16'd41;
    return p[15:12];
  endfunction

endpackage

// ----- rtl/icp_modunit.sv -----
// Serial remainder unit: 64-bit dividend modulo a narrow divisor, 8 bits per cycle.
// Standalone; the divisor must stay stable while the unit is busy.
module icp_modunit #(
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int STEPS = 8;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [63:0]   dv_r, dv_nxt;
  logic [DW-1:0] rem_r, rem_nxt;

  always_comb begin
    logic [DW:0]  t;
    logic [63:0]  d;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    t = {1'b0, rem_r};
    d = dv_r;
    for (int k = 0; k < STEPS; k++) begin
      t = {t[DW-1:0], d[63]};
      d = {d[62:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dv_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dv_nxt  = d;
      rem_nxt = t[DW-1:0];
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/intcode_processor.sv -----
// Intcode processor top level: command decode, sequencer and program memories.
// Depends on icp_pkg and icp_modunit.
//
// Restart copies the pristine image into working memory, and after reset a clearing
// pass zeroes both memories before the first item is taken. A run item executes
// instructions one at a time against the working memory: each instruction passes
// through fetch and dispatch, a decimal decode in the serial remainder unit, a parameter
// step for each immediate parameter and a memory read as well for each memory parameter,
// operand reads and execution, a split multiply for multiply, and another pass through
// the remainder unit when the pointer wraps or when a jump is taken. A negative word is
// skipped, as is any other unknown opcode. A run executes up to 65536 instructions,
// after which it returns without a result.
module intcode_processor
  import icp_pkg::*;
#(
  parameter int MEM_DEPTH   = 4096,
  parameter int INPUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic [2:0]  out_status
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int PW = $clog2(MEM_DEPTH + 1);
  localparam int QW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int CW = $clog2(INPUT_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int DW = (PW > DEC_W) ? PW : DEC_W;

  logic [63:0] wmem [MEM_DEPTH];
  logic [63:0] pmem [MEM_DEPTH];
  logic [63:0] qmem [INPUT_DEPTH];

  state_t        state_r, state_nxt;
  logic [AW:0]   sweep_r, sweep_nxt;
  logic [PW-1:0] plen_r, plen_nxt;
  logic [AW-1:0] ip_r, ip_nxt;
  logic [63:0]   rb_r, rb_nxt;
  logic [CW-1:0] qcnt_r, qcnt_nxt;
  logic [QW-1:0] qrd_r, qrd_nxt;
  logic [BW-1:0] steps_r, steps_nxt;
  logic [9:0]    m_r, m_nxt;
  logic [16:0]   dr_r, dr_nxt;
  logic [6:0]    op_r, op_nxt;
  logic [3:0]    mode_r [3];
  logic [3:0]    mode_nxt [3];
  logic [1:0]    np_r, np_nxt;
  logic [1:0]    pi_r, pi_nxt;
  logic [AW-1:0] ad_r [3];
  logic [AW-1:0] ad_nxt [3];
  logic [63:0]   a_r, a_nxt, b_r, b_nxt;
  logic [63:0]   prod_r, prod_nxt, acc_r, acc_nxt;
  logic [2:0]    advn_r, advn_nxt;
  logic          emit_r, emit_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic [63:0]   res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_value_r, out_value_nxt;
  logic [2:0]    out_status_r, out_status_nxt;

  logic          wm_we, pm_we, q_we;
  logic [AW-1:0] wm_waddr, wm_raddr, pm_raddr;
  logic [63:0]   wm_wdata;
  logic [63:0]   wm_rd_r, pm_rd_r, q_rd_r;
  logic [QW-1:0] q_waddr;

  logic          mu_start, mu_done;
  logic [63:0]   mu_dividend;
  logic [DW-1:0] mu_divisor, mu_rem;
  logic [31:0]   mul_x, mul_y;
  logic [63:0]   mul_p;

  logic accept;

  icp_modunit #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mu_start),
    .dividend (mu_dividend),
    .divisor  (mu_divisor),
    .done     (mu_done),
    .rem      (mu_rem)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign mu_divisor = (state_r == S_DEC) ? DW'(DEC_BASE) : DW'(plen_r);
  assign mul_p      = mul_x * mul_y;
  assign pm_raddr   = sweep_r[AW-1:0];

  always_comb begin
    logic [SW-1:0] qsum;
    logic [AW:0]   w;
    logic [AW:0]   sum;
    logic [63:0]   eff;
    logic [3:0]    md;
    logic [6:0]    q10;
    logic [3:0]    q100;
    logic [16:0]   opw;
    logic          cond;

    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    plen_nxt       = plen_r;
    ip_nxt         = ip_r;
    rb_nxt         = rb_r;
    qcnt_nxt       = qcnt_r;
    qrd_nxt        = qrd_r;
    steps_nxt      = steps_r;
    m_nxt          = m_r;
    dr_nxt         = dr_r;
    op_nxt         = op_r;
    mode_nxt       = mode_r;
    np_nxt         = np_r;
    pi_nxt         = pi_r;
    ad_nxt         = ad_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    advn_nxt       = advn_r;
    emit_nxt       = emit_r;
    stat_nxt       = stat_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    wm_we          = 1'b0;
    pm_we          = 1'b0;
    q_we           = 1'b0;
    wm_waddr       = AW'(in_address);
    wm_wdata       = in_value;
    wm_raddr       = ip_r;
    mu_start       = 1'b0;
    mu_dividend    = b_r;
    mul_x          = a_r[31:0];
    mul_y          = b_r[31:0];

    qsum = SW'(qrd_r) + SW'(qcnt_r);
    if (qsum >= SW'(INPUT_DEPTH)) begin
      qsum = qsum - SW'(INPUT_DEPTH);
    end
    q_waddr = qsum[QW-1:0];

    w    = (AW + 1)'(ip_r) + (AW + 1)'(pi_r) + (AW + 1)'(1);
    sum  = (AW + 1)'(ip_r) + (AW + 1)'(advn_r);
    md   = mode_r[pi_r];
    eff  = wm_rd_r + ((md == MODE_REL) ? rb_r : 64'd0);
    q10  = div10(m_r);
    q100 = div100s(m_r);
    opw  = dr_r - 17'(m_r) * 17'd100;
    cond = ((op_r == OP_JT) == (a_r != 64'd0));

    case (state_r)
      S_CLEAR: begin
        wm_we     = 1'b1;
        pm_we     = 1'b1;
        wm_waddr  = sweep_r[AW-1:0];
        wm_wdata  = 64'd0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (AW + 1)'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: begin
              if (32'(in_address) < 32'(MEM_DEPTH)) begin
                wm_we = 1'b1;
                pm_we = 1'b1;
                if (32'(in_address) + 32'd1 > 32'(plen_r)) begin
                  plen_nxt = PW'(32'(in_address) + 32'd1);
                end
              end
            end
            CMD_PUSH: begin
              if (32'(qcnt_r) < 32'(INPUT_DEPTH)) begin
                q_we     = 1'b1;
                qcnt_nxt = qcnt_r + 1'b1;
              end
            end
            CMD_RESTART: begin
              ip_nxt    = '0;
              rb_nxt    = '0;
              qcnt_nxt  = '0;
              qrd_nxt   = '0;
              sweep_nxt = '0;
              state_nxt = S_COPY;
            end
            CMD_RUN: begin
              steps_nxt = '0;
              emit_nxt  = 1'b0;
              state_nxt = S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        if (sweep_r != '0) begin
          wm_we    = 1'b1;
          wm_waddr = AW'(sweep_r - 1'b1);
          wm_wdata = pm_rd_r;
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (AW + 1)'(MEM_DEPTH)) begin
          state_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        if (32'(ip_r) >= 32'(plen_r)) begin
          stat_nxt  = ST_HALT;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        // Every negative word has a remainder below one, so it is skipped.
        if (wm_rd_r[63]) begin
          advn_nxt  = 3'd1;
          state_nxt = S_ADV;
        end else begin
          mu_start    = 1'b1;
          mu_dividend = wm_rd_r;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (mu_done) begin
          dr_nxt    = mu_rem[DEC_W-1:0];
          m_nxt     = div100(mu_rem[DEC_W-1:0]);
          state_nxt = S_DEC2;
        end
      end
      S_DEC2: begin
        mode_nxt[0] = 4'(m_r - 10'(q10) * 10'd10);
        mode_nxt[1] = 4'(q10 - 7'(q100) * 7'd10);
        mode_nxt[2] = q100;
        op_nxt      = opw[6:0];
        pi_nxt      = '0;
        if (opw[6:0] == OP_HALT) begin
          stat_nxt  = ST_HALT;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else if (opw[6:0] < OP_ADD || opw[6:0] > OP_ARB) begin
          advn_nxt  = 3'd1;
          state_nxt = S_ADV;
        end else begin
          if (opw[6:0] == OP_IN || opw[6:0] == OP_OUT || opw[6:0] == OP_ARB) begin
            np_nxt = 2'd1;
          end else if (opw[6:0] == OP_JT || opw[6:0] == OP_JF) begin
            np_nxt = 2'd2;
          end else begin
            np_nxt = 2'd3;
          end
          state_nxt = S_PAR;
        end
      end
      S_PAR: begin
        if (md > MODE_REL) begin
          stat_nxt  = ST_BADMODE;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else if (32'(w) >= 32'(MEM_DEPTH)) begin
          stat_nxt  = ST_RANGE;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else if (md == MODE_IMM) begin
          ad_nxt[pi_r] = w[AW-1:0];
          if (pi_r + 2'd1 == np_r) begin
            state_nxt = S_OPR;
          end else begin
            pi_nxt = pi_r + 2'd1;
          end
        end else begin
          wm_raddr  = w[AW-1:0];
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (eff >= 64'(MEM_DEPTH)) begin
          stat_nxt  = ST_RANGE;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          ad_nxt[pi_r] = eff[AW-1:0];
          if (pi_r + 2'd1 == np_r) begin
            state_nxt = S_OPR;
          end else begin
            pi_nxt    = pi_r + 2'd1;
            state_nxt = S_PAR;
          end
        end
      end
      S_OPR: begin
        wm_raddr  = ad_r[0];
        state_nxt = S_OPA;
      end
      S_OPA: begin
        a_nxt     = wm_rd_r;
        wm_raddr  = ad_r[1];
        state_nxt = S_OPB;
      end
      S_OPB: begin
        b_nxt     = wm_rd_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            wm_we     = 1'b1;
            wm_waddr  = ad_r[2];
            wm_wdata  = a_r + b_r;
            advn_nxt  = 3'd4;
            state_nxt = S_ADV;
          end
          OP_MUL: begin
            state_nxt = S_MUL1;
          end
          OP_IN: begin
            if (qcnt_r == '0) begin
              stat_nxt  = ST_UNDERRUN;
              res_nxt   = '0;
              state_nxt = S_EMIT;
            end else begin
              wm_we    = 1'b1;
              wm_waddr = ad_r[0];
              wm_wdata = q_rd_r;
              qrd_nxt  = (qrd_r == QW'(INPUT_DEPTH - 1)) ? '0 : qrd_r + 1'b1;
              qcnt_nxt = qcnt_r - 1'b1;
              advn_nxt  = 3'd2;
              state_nxt = S_ADV;
            end
          end
          OP_OUT: begin
            emit_nxt  = 1'b1;
            stat_nxt  = ST_OUTPUT;
            res_nxt   = a_r;
            advn_nxt  = 3'd2;
            state_nxt = S_ADV;
          end
          OP_JT, OP_JF: begin
            if (cond) begin
              if (b_r[63]) begin
                stat_nxt  = ST_RANGE;
                res_nxt   = '0;
                state_nxt = S_EMIT;
              end else begin
                mu_start    = 1'b1;
                mu_dividend = b_r;
                state_nxt   = S_MODW;
              end
            end else begin
              advn_nxt  = 3'd3;
              state_nxt = S_ADV;
            end
          end
          OP_LT: begin
            wm_we     = 1'b1;
            wm_waddr  = ad_r[2];
            wm_wdata  = {63'd0, ($signed(a_r) < $signed(b_r))};
            advn_nxt  = 3'd4;
            state_nxt = S_ADV;
          end
          OP_EQ: begin
            wm_we     = 1'b1;
            wm_waddr  = ad_r[2];
            wm_wdata  = {63'd0, (a_r == b_r)};
            advn_nxt  = 3'd4;
            state_nxt = S_ADV;
          end
          OP_ARB: begin
            rb_nxt    = rb_r + a_r;
            advn_nxt  = 3'd2;
            state_nxt = S_ADV;
          end
          default: begin
            advn_nxt  = 3'd1;
            state_nxt = S_ADV;
          end
        endcase
      end
      S_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = prod_r;
        mul_y     = b_r[63:32];
        prod_nxt  = mul_p;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
        mul_x     = a_r[63:32];
        prod_nxt  = mul_p;
        state_nxt = S_MUL4;
      end
      S_MUL4: begin
        wm_we     = 1'b1;
        wm_waddr  = ad_r[2];
        wm_wdata  = acc_r + {prod_r[31:0], 32'd0};
        advn_nxt  = 3'd4;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if (32'(sum) < 32'(plen_r)) begin
          ip_nxt    = sum[AW-1:0];
          state_nxt = S_NEXT;
        end else begin
          mu_start    = 1'b1;
          mu_dividend = 64'(sum);
          state_nxt   = S_MODW;
        end
      end
      S_MODW: begin
        if (mu_done) begin
          ip_nxt    = mu_rem[AW-1:0];
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (emit_r) begin
          state_nxt = S_EMIT;
        end else if (steps_r == BW'(RUN_BUDGET - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      plen_r      <= '0;
      ip_r        <= '0;
      rb_r        <= '0;
      qcnt_r      <= '0;
      qrd_r       <= '0;
      steps_r     <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      plen_r      <= plen_nxt;
      ip_r        <= ip_nxt;
      rb_r        <= rb_nxt;
      qcnt_r      <= qcnt_nxt;
      qrd_r       <= qrd_nxt;
      steps_r     <= steps_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r          <= m_nxt;
    dr_r         <= dr_nxt;
    op_r         <= op_nxt;
    mode_r       <= mode_nxt;
    np_r         <= np_nxt;
    pi_r         <= pi_nxt;
    ad_r         <= ad_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    advn_r       <= advn_nxt;
    stat_r       <= stat_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    wm_rd_r <= wmem[wm_raddr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[wm_waddr] <= wm_wdata;
    end
    pm_rd_r <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= in_value;
    end
    q_rd_r <= qmem[qrd_r];
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- bench/intcode_checker.sv -----
// Checker for the intcode processor: watches both channels, predicts each run result
// and compares every result transfer against the oldest prediction.
// Depends on icp_pkg for the command, status, opcode and mode codes and the run budget.
`timescale 1ns / 1ps

module intcode_checker
  import icp_pkg::*;
#(
  parameter int MEM_DEPTH   = 4096,
  parameter int INPUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [63:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_value,
  input  logic [2:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } vm_result_t;

  logic [63:0] image_mem [MEM_DEPTH];
  logic [63:0] work_mem [MEM_DEPTH];
  logic [63:0] in_fifo [INPUT_DEPTH];
  int unsigned prog_len;
  int unsigned pc;
  logic [63:0] rel_base;
  int unsigned fifo_count;
  int unsigned fifo_rd;
  vm_result_t  awaited_results[$];

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int mode_digit(input longint ps, input int p);
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] d;
    int nd;
    int k;
    mag = (ps < 0) ? 64'd0 - 64'(ps) : 64'(ps);
    t = mag;
    nd = 0;
    while (t != 0) begin
      nd++;
      t = t / 10;
    end
    if (p <= nd) begin
      d = mag;
      for (k = 1; k < p; k++) d = d / 10;
      d = d % 10;
      return (d > 2) ? -1 : int'(d);
    end
    if (p == nd + 1 && ps < 0) return -1;
    return 0;
  endfunction

  // Returns -1 when the parameter resolves, or the fault status.
  function automatic int operand_addr(input longint ps, input int p,
                                      output int unsigned addr);
    int m;
    int unsigned w;
    logic [63:0] a;
    addr = 0;
    m = mode_digit(ps, p);
    w = pc + p;
    if (m < 0) return int'(ST_BADMODE);
    if (w >= MEM_DEPTH) return int'(ST_RANGE);
    if (m == int'(MODE_IMM)) begin
      addr = w;
      return -1;
    end
    a = work_mem[w];
    if (m == int'(MODE_REL)) a = a + rel_base;
    if (a >= MEM_DEPTH) return int'(ST_RANGE);
    addr = int'(a);
    return -1;
  endfunction

  task automatic execute_run(output bit done, output vm_result_t res);
    longint inst;
    longint ps;
    longint op;
    int n;
    int r;
    int p;
    int steps;
    int unsigned ad [3];
    logic [63:0] a;
    logic [63:0] b;
    done = 1'b0;
    res = '0;
    ad = '{default: 0};
    for (steps = 0; steps < RUN_BUDGET; steps++) begin
      if (pc >= prog_len) begin
        done = 1'b1;
        res.status = ST_HALT;
        return;
      end
      inst = longint'(work_mem[pc]);
      ps = inst / 100;
      op = inst % 100;
      if (op == longint'(OP_HALT)) begin
        done = 1'b1;
        res.status = ST_HALT;
        return;
      end
      if (op < 1 || op > 9) begin
        pc = (pc + 1) % prog_len;
        continue;
      end
      if (op == longint'(OP_IN) || op == longint'(OP_OUT) || op == longint'(OP_ARB)) n = 1;
      else if (op == longint'(OP_JT) || op == longint'(OP_JF)) n = 2;
      else n = 3;
      for (p = 1; p <= n; p++) begin
        r = operand_addr(ps, p, ad[p-1]);
        if (r >= 0) begin
          done = 1'b1;
          res.status = r[2:0];
          return;
        end
      end
      a = work_mem[ad[0]];
      b = (n >= 2) ? work_mem[ad[1]] : 64'd0;
      case (op[6:0])
        OP_ADD: begin
          work_mem[ad[2]] = a + b;
          pc = (pc + 4) % prog_len;
        end
        OP_MUL: begin
          work_mem[ad[2]] = a * b;
          pc = (pc + 4) % prog_len;
        end
        OP_IN: begin
          if (fifo_count == 0) begin
            done = 1'b1;
            res.status = ST_UNDERRUN;
            return;
          end
          work_mem[ad[0]] = in_fifo[fifo_rd % INPUT_DEPTH];
          fifo_rd = (fifo_rd + 1) % INPUT_DEPTH;
          fifo_count--;
          pc = (pc + 2) % prog_len;
        end
        OP_OUT: begin
          pc = (pc + 2) % prog_len;
          done = 1'b1;
          res.value = a;
          res.status = ST_OUTPUT;
          return;
        end
        OP_JT, OP_JF: begin
          if ((op == longint'(OP_JT)) == (a != 0)) begin
            if (b[63]) begin
              done = 1'b1;
              res.status = ST_RANGE;
              return;
            end
            pc = int'(b % prog_len);
          end else begin
            pc = (pc + 3) % prog_len;
          end
        end
        OP_LT: begin
          work_mem[ad[2]] = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
          pc = (pc + 4) % prog_len;
        end
        OP_EQ: begin
          work_mem[ad[2]] = (a == b) ? 64'd1 : 64'd0;
          pc = (pc + 4) % prog_len;
        end
        default: begin
          rel_base = rel_base + a;
          pc = (pc + 2) % prog_len;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    bit         done;
    vm_result_t res;
    vm_result_t exp_res;
    if (!rst_n) begin
      foreach (image_mem[i]) begin
        image_mem[i] = '0;
        work_mem[i] = '0;
      end
      prog_len = 0;
      pc = 0;
      rel_base = '0;
      fifo_count = 0;
      fifo_rd = 0;
      awaited_results.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_LOAD: begin
            image_mem[in_address] = in_value;
            work_mem[in_address] = in_value;
            if (int'(in_address) + 1 > prog_len) prog_len = int'(in_address) + 1;
          end
          CMD_PUSH: begin
            if (fifo_count < INPUT_DEPTH) begin
              in_fifo[(fifo_rd + fifo_count) % INPUT_DEPTH] = in_value;
              fifo_count++;
            end
          end
          CMD_RESTART: begin
            foreach (work_mem[i]) work_mem[i] = image_mem[i];
            pc = 0;
            rel_base = '0;
            fifo_count = 0;
            fifo_rd = 0;
          end
          default: begin
            execute_run(done, res);
            if (done) awaited_results.push_back(res);
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with no result outstanding");
        end else begin
          exp_res = awaited_results.pop_front();
          results_seen++;
          if (out_status !== exp_res.status)
            report_mismatch($sformatf("status %0d, predicted %0d", out_status, exp_res.status));
          if (out_value !== exp_res.value)
            report_mismatch($sformatf("value %h, predicted %h", out_value, exp_res.value));
        end
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- bench/intcode_processor_test.sv -----
// Top of the intcode processor testbench: clock, reset, command stimulus and verdict.
// Depends on icp_pkg, the intcode_processor block and the intcode_checker module.
`timescale 1ns / 1ps

module intcode_processor_test;
  import icp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [11:0] in_address;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_value;
  logic [2:0]  out_status;
  int          fail_count;
  int          pending;
  int          results_seen;

  int          items_sent;
  int          programs_built;
  bit          calm;
  int          stall_left;
  logic [63:0] prog_words[$];

  intcode_processor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  intcode_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_address(in_address), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  // Alternates between stretches with random stalls and stretches without any.
  always @(posedge clk) begin
    if ($urandom_range(0, 2999) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm) begin
        case ($urandom_range(0, 99)) inside
          [0:19]:  stall_left <= $urandom_range(1, 3);
          [20:23]: stall_left <= $urandom_range(20, 80);
          default: stall_left <= 0;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return 64'd0;
      3: return '1;
      4, 5: return 64'(longint'($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Turns a word that would decode as a jump into one that does not.
  function automatic logic [63:0] no_jump(input logic [63:0] w);
    longint r;
    r = longint'(w) % 100;
    if (r == longint'(OP_JT) || r == longint'(OP_JF)) return w + 64'd2;
    return w;
  endfunction

  task automatic send(input logic [1:0] c, input logic [11:0] a, input logic [63:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_address <= a;
    in_value <= v;
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic void read_operand(output int m, output logic [63:0] w);
    m = $urandom_range(0, 2);
    if (m == int'(MODE_IMM)) w = pick_word();
    else w = 64'($urandom_range(200, 215));
  endfunction

  // Straight-line code with forward jumps only, writes kept in the data area
  // and a halt at the end, so every run stops well inside the step budget.
  task automatic build_program();
    int n;
    int i;
    int pos;
    int m1;
    int m2;
    int ops [10];
    int starts [11];
    logic [63:0] w1;
    logic [63:0] w2;
    prog_words.delete();
    n = $urandom_range(3, 10);
    pos = 0;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0, 1: ops[i] = int'(OP_ADD);
        2: ops[i] = int'(OP_MUL);
        3: ops[i] = int'(OP_IN);
        4, 5: ops[i] = int'(OP_OUT);
        6: ops[i] = int'(OP_JT);
        7: ops[i] = int'(OP_JF);
        8: ops[i] = int'(OP_LT);
        9: ops[i] = int'(OP_EQ);
        10: ops[i] = int'(OP_ARB);
        default: ops[i] = 0;
      endcase
      starts[i] = pos;
      if (ops[i] == 0) pos += 1;
      else if (ops[i] == int'(OP_IN) || ops[i] == int'(OP_OUT) || ops[i] == int'(OP_ARB))
        pos += 2;
      else if (ops[i] == int'(OP_JT) || ops[i] == int'(OP_JF)) pos += 3;
      else pos += 4;
    end
    starts[n] = pos;
    for (i = 0; i < n; i++) begin
      read_operand(m1, w1);
      read_operand(m2, w2);
      case (ops[i])
        0: prog_words.push_back(64'($urandom_range(10, 98)));
        int'(OP_IN): begin
          prog_words.push_back(64'(OP_IN));
          prog_words.push_back(64'($urandom_range(200, 215)));
        end
        int'(OP_OUT): begin
          prog_words.push_back(64'(ops[i] + 100 * m1));
          prog_words.push_back(w1);
        end
        int'(OP_ARB): begin
          if (m1 == int'(MODE_IMM)) w1 = 64'(longint'($urandom_range(0, 16)) - 8);
          prog_words.push_back(64'(ops[i] + 100 * m1));
          prog_words.push_back(w1);
        end
        int'(OP_JT), int'(OP_JF): begin
          prog_words.push_back(64'(ops[i] + 100 * m1 + 1000));
          prog_words.push_back(w1);
          prog_words.push_back(64'(starts[$urandom_range(i + 1, n)]));
        end
        default: begin
          prog_words.push_back(64'(ops[i] + 100 * m1 + 1000 * m2));
          prog_words.push_back(w1);
          prog_words.push_back(w2);
          prog_words.push_back(64'($urandom_range(200, 215)));
        end
      endcase
    end
    prog_words.push_back(64'(OP_HALT));
  endtask

  // Loosely formed code: random modes including bad ones, random words, no jumps
  // by construction, ending in enough halts that no instruction can step past them.
  task automatic build_noise();
    int n;
    int i;
    int opc;
    prog_words.delete();
    n = $urandom_range(2, 12);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: prog_words.push_back(no_jump(pick_word()));
        1, 2: prog_words.push_back(no_jump(64'($urandom_range(200, 215))));
        default: begin
          case ($urandom_range(0, 9))
            0: opc = int'(OP_ADD);
            1: opc = int'(OP_MUL);
            2: opc = int'(OP_IN);
            3, 4: opc = int'(OP_OUT);
            5: opc = int'(OP_LT);
            6: opc = int'(OP_EQ);
            7: opc = int'(OP_ARB);
            8: opc = int'(OP_HALT);
            default: opc = 42;
          endcase
          prog_words.push_back(64'(opc + 100 * $urandom_range(0, 3) +
                                   1000 * $urandom_range(0, 2) + 10000 * $urandom_range(0, 2)));
        end
      endcase
    end
    repeat (4) prog_words.push_back(64'(OP_HALT));
  endtask

  task automatic load_and_run();
    int k;
    int runs;
    for (k = 0; k < prog_words.size(); k++) send(CMD_LOAD, 12'(k), prog_words[k]);
    repeat ($urandom_range(0, 4)) send(CMD_LOAD, 12'($urandom_range(200, 215)), pick_word());
    if ($urandom_range(0, 9) != 0) send(CMD_RESTART, 12'($urandom), pick_word());
    repeat ($urandom_range(0, 5)) send(CMD_PUSH, 12'($urandom), pick_word());
    runs = $urandom_range(2, 8);
    for (k = 0; k < runs; k++) begin
      if ($urandom_range(0, 5) == 0) send(CMD_PUSH, 12'($urandom), pick_word());
      send(CMD_RUN, 12'($urandom), pick_word());
    end
    programs_built++;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_LOAD;
    in_address <= '0;
    in_value <= '0;
    calm <= 1'b0;
    items_sent = 0;
    programs_built = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty program, a queue overrun, then output, halt and underrun.
    send(CMD_RUN, 12'd0, 64'd0);
    send(CMD_PUSH, 12'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send(CMD_PUSH, 12'd0, 64'h8000_0000_0000_0000);
    send(CMD_PUSH, 12'd0, 64'd0);
    send(CMD_PUSH, 12'd0, '1);
    send(CMD_PUSH, 12'd0, 64'd1);
    send(CMD_LOAD, 12'd0, 64'(OP_IN));
    send(CMD_LOAD, 12'd1, 64'd100);
    send(CMD_LOAD, 12'd2, 64'(OP_OUT));
    send(CMD_LOAD, 12'd3, 64'd100);
    send(CMD_LOAD, 12'd4, 64'(OP_HALT));
    send(CMD_RUN, 12'd0, 64'd0);
    send(CMD_RUN, 12'd0, 64'd0);
    send(CMD_RESTART, 12'd0, 64'd0);
    send(CMD_RUN, 12'd0, 64'd0);
    // Bad mode digit, operand address beyond memory, negative jump target.
    send(CMD_LOAD, 12'd0, 64'd301);
    send(CMD_RUN, 12'd0, 64'd0);
    send(CMD_LOAD, 12'd0, 64'(OP_OUT));
    send(CMD_LOAD, 12'd1, 64'd5000);
    send(CMD_RUN, 12'd0, 64'd0);
    send(CMD_LOAD, 12'd0, 64'd1105);
    send(CMD_LOAD, 12'd1, 64'd1);
    send(CMD_LOAD, 12'd2, 64'(-64'sd5));
    send(CMD_RUN, 12'd0, 64'd0);
    // A negative opcode word is skipped.
    send(CMD_LOAD, 12'd0, 64'(-64'sd7));
    send(CMD_RUN, 12'd0, 64'd0);

    while (items_sent < 1850) begin
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_program();
      load_and_run();
    end

    // Highest address: the program spans all of memory and the pointer wraps.
    send(CMD_LOAD, 12'hFFF, '1);
    send(CMD_LOAD, 12'd0, 64'(OP_OUT));
    send(CMD_LOAD, 12'd1, 64'd4095);
    send(CMD_LOAD, 12'd2, 64'd0);
    send(CMD_RESTART, 12'hFFF, '1);
    send(CMD_RUN, 12'hFFF, '1);
    send(CMD_RUN, 12'hFFF, '1);
    send(CMD_RUN, 12'hFFF, '1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("Sent %0d items over %0d programs; %0d run results checked.",
             items_sent, programs_built, results_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/icp_pkg.sv
rtl/icp_modunit.sv
rtl/intcode_processor.sv
bench/intcode_checker.sv
bench/intcode_processor_test.sv
